// ----- rtl/odr_pkg.sv -----
package odr_pkg;

	localparam int MATRIX_SIDE_MAX = 8;
	localparam int LINE_WIDTH_MAX  = 4096;

	localparam int SIDE_W   = $clog2(MATRIX_SIDE_MAX);
	localparam int SIZE_W   = $clog2(MATRIX_SIDE_MAX + 1);
	localparam int ADDR_W   = $clog2(MATRIX_SIDE_MAX * MATRIX_SIDE_MAX);
	localparam int DEPTH    = MATRIX_SIDE_MAX * MATRIX_SIDE_MAX;
	localparam int CELLS_W  = 2 * SIZE_W;
	localparam int SCALE_W  = $clog2(MATRIX_SIDE_MAX * MATRIX_SIDE_MAX + 2);
	localparam int LINE_W   = $clog2(LINE_WIDTH_MAX);
	localparam int IMG_W    = 13;
	localparam int CFG_W    = 13;

	localparam logic [7:0] PIX_OFF = 8'h00;
	localparam logic [7:0] PIX_ON  = 8'hFF;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_MATRIX_WIDTH  = 2'd1,
		CFG_MATRIX_HEIGHT = 2'd2
	} cfg_index_t;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_ENTRY = 1'b1
	} mode_t;

	typedef struct packed {
		logic       mode;
		logic       frame_start;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [2:0] entry_row;
		logic [2:0] entry_col;
		logic [7:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} out_item_t;

	// Effective sizes after the zero and oversize cases are folded in.
	typedef struct packed {
		logic [IMG_W-1:0]  line_w;
		logic [SIZE_W-1:0] mat_w;
		logic [SIZE_W-1:0] mat_h;
	} sizes_t;

	typedef struct packed {
		logic [SIDE_W-1:0] row;
		logic [SIDE_W-1:0] col;
	} phase_t;

	function automatic logic [SIZE_W-1:0] clamp_side(input logic [3:0] v);
		logic [SIZE_W-1:0] r;
		if (v == 4'd0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > MATRIX_SIDE_MAX) begin
			r = SIZE_W'(MATRIX_SIDE_MAX);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

	function automatic logic [IMG_W-1:0] clamp_line(input logic [IMG_W-1:0] v);
		logic [IMG_W-1:0] r;
		if (v == '0) begin
			r = IMG_W'(1);
		end else if (32'(v) > LINE_WIDTH_MAX) begin
			r = IMG_W'(LINE_WIDTH_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- rtl/ordered_dither_rgb.sv -----
// Ordered dithering of an RGB pixel stream to one bit per channel. Items with
// mode 1 load one threshold matrix entry and give no result; items with mode 0
// are pixels in raster order and give one result each. The block takes one
// item per clock when out_ready does not hold the pipeline. An accepted pixel
// captures the registered read of the 64-entry threshold memory in stage 1,
// and the three channel compares are then captured into the output register
// once that register can load. Every matrix entry a pixel will use must
// be loaded first; there is no clearing after reset.
// Configuration writes take effect at once and belong between frames.
module ordered_dither_rgb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  odr_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output odr_pkg::out_item_t          out_data,
	input  logic                        cfg_write_en,
	input  odr_pkg::cfg_index_t         cfg_index,
	input  logic [odr_pkg::CFG_W-1:0]   cfg_data
);
	import odr_pkg::*;

	logic [IMG_W-1:0] image_width_q;
	logic [3:0]       matrix_width_q;
	logic [3:0]       matrix_height_q;

	sizes_t               sizes;
	logic [CELLS_W-1:0]   cells;
	logic [SCALE_W-1:0]   scale;

	logic        in_fire;
	logic        pix_fire;
	logic        entry_fire;
	phase_t      phase;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	logic [7:0]  matrix_mem [DEPTH];

	logic        valid_s1;
	logic [7:0]  rank_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;
	logic        s1_load;
	logic        s2_load;
	out_item_t   lane_res;
	out_item_t   out_q;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= IMG_W'(512);
			matrix_width_q  <= 4'd8;
			matrix_height_q <= 4'd8;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data[IMG_W-1:0];
				CFG_MATRIX_WIDTH:  matrix_width_q  <= cfg_data[3:0];
				CFG_MATRIX_HEIGHT: matrix_height_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign sizes.line_w = clamp_line(image_width_q);
	assign sizes.mat_w  = clamp_side(matrix_width_q);
	assign sizes.mat_h  = clamp_side(matrix_height_q);
	assign cells        = CELLS_W'(sizes.mat_w) * CELLS_W'(sizes.mat_h);
	assign scale        = SCALE_W'(cells) + SCALE_W'(1);

	// Stage 1 may take a new item when empty or when its item moves on.
	assign s2_load    = !out_valid_q || out_ready;
	assign s1_load    = !valid_s1 || s2_load;
	assign in_ready   = s1_load;
	assign in_fire    = in_valid && in_ready;
	assign pix_fire   = in_fire && (in_data.mode == MODE_PIXEL);
	assign entry_fire = in_fire && (in_data.mode == MODE_ENTRY);

	odr_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (pix_fire),
		.frame_start (in_data.frame_start),
		.sizes       (sizes),
		.phase       (phase)
	);

	assign rd_addr = ADDR_W'(phase.row) * ADDR_W'(MATRIX_SIDE_MAX) + ADDR_W'(phase.col);
	assign wr_addr = ADDR_W'(in_data.entry_row) * ADDR_W'(MATRIX_SIDE_MAX)
		+ ADDR_W'(in_data.entry_col);

	always_ff @(posedge clk) begin
		if (entry_fire) begin
			matrix_mem[wr_addr] <= in_data.entry_value;
		end
		if (pix_fire) begin
			rank_s1  <= matrix_mem[rd_addr];
			red_s1   <= in_data.red_in;
			green_s1 <= in_data.green_in;
			blue_s1  <= in_data.blue_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= pix_fire;
		end
	end

	odr_lane u_lane_red (
		.value  (red_s1),
		.rank   (rank_s1),
		.scale  (scale),
		.result (lane_res.red_out)
	);

	odr_lane u_lane_green (
		.value  (green_s1),
		.rank   (rank_s1),
		.scale  (scale),
		.result (lane_res.green_out)
	);

	odr_lane u_lane_blue (
		.value  (blue_s1),
		.rank   (rank_s1),
		.scale  (scale),
		.result (lane_res.blue_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			out_q <= lane_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_entry_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		entry_fire |=> !valid_s1)
		else $error("matrix load item entered the pixel pipeline");

	a_frame_start_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_fire && in_data.frame_start) |-> (rd_addr == '0))
		else $error("frame start pixel does not read the matrix origin");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_load) |=> (valid_s1 && $stable(rank_s1) && $stable(red_s1)))
		else $error("stalled stage 1 item changed");

	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.red_out == PIX_OFF || out_data.red_out == PIX_ON)
			&& (out_data.green_out == PIX_OFF || out_data.green_out == PIX_ON)
			&& (out_data.blue_out == PIX_OFF || out_data.blue_out == PIX_ON)))
		else $error("result channel is neither off nor on");

endmodule

// ----- rtl/odr_pos.sv -----
module odr_pos (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           frame_start,
	input  odr_pkg::sizes_t sizes,
	output odr_pkg::phase_t phase
);
	import odr_pkg::*;

	logic [LINE_W-1:0] line_pos_q;
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W-1:0] row_q;

	logic [LINE_W-1:0] cur_line;
	logic [SIDE_W-1:0] cur_col;
	logic [SIDE_W-1:0] cur_row;
	logic              line_end;
	logic              col_wrap;
	logic              row_wrap;

	// A frame start clears the counters before the pixel uses them.
	assign cur_line = frame_start ? '0 : line_pos_q;
	assign cur_col  = frame_start ? '0 : col_q;
	assign cur_row  = frame_start ? '0 : row_q;

	assign line_end = ({1'b0, cur_line} + (LINE_W+1)'(1)) >= (LINE_W+1)'(sizes.line_w);
	assign col_wrap = ({1'b0, cur_col} + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(sizes.mat_w);
	assign row_wrap = ({1'b0, cur_row} + (SIDE_W+1)'(1)) >= (SIDE_W+1)'(sizes.mat_h);

	assign phase.row = cur_row;
	assign phase.col = cur_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pos_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (step) begin
			if (line_end) begin
				line_pos_q <= '0;
				col_q      <= '0;
				row_q      <= row_wrap ? '0 : cur_row + SIDE_W'(1);
			end else begin
				line_pos_q <= cur_line + LINE_W'(1);
				col_q      <= col_wrap ? '0 : cur_col + SIDE_W'(1);
				row_q      <= cur_row;
			end
		end
	end

endmodule

// ----- rtl/odr_lane.sv -----
module odr_lane (
	input  logic [7:0]                 value,
	input  logic [7:0]                 rank,
	input  logic [odr_pkg::SCALE_W-1:0] scale,
	output logic [7:0]                 result
);
	import odr_pkg::*;

	localparam int LHS_W = 8 + SCALE_W;

	logic [LHS_W-1:0] lhs;
	logic [8:0]       rank_p1;
	logic [16:0]      rhs;

	// value * (1 + W*H) against (1 + rank) * 255, both exact integers.
	assign lhs     = LHS_W'(value) * LHS_W'(scale);
	assign rank_p1 = {1'b0, rank} + 9'd1;
	assign rhs     = 17'(rank_p1) * 17'd255;
	assign result  = (17'(lhs) < rhs) ? PIX_OFF : PIX_ON;

endmodule
